@@ hdl/top4_peak_tracker_unit_macros.svh @@
// assertion macros for the peak tracker
`ifndef TOP4_PEAK_TRACKER_UNIT_MACROS_SVH
`define TOP4_PEAK_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define TPT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("tpt assertion failed");

// condition that must be followed by a consequence in the next cycle
`define TPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpt assertion failed");

`else

`define TPT_ASSERT_ALWAYS(lbl, expr)
`define TPT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/tpt_pkg.sv @@
`default_nettype none

package tpt_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned BIN_W   = 10;
  localparam int unsigned TIMER_W = 32;
  localparam int unsigned COUNT_W = TIMER_W - 1;
  localparam int unsigned SLOTS   = 4;

  localparam logic [TIMER_W-1:0] FLUSH_RESET = 32'd1024;

  // one kept peak
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } slot_t;

  // broadcast from the control logic to every cell
  typedef struct packed {
    logic  accept;
    logic  flush;
    slot_t entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/tpt_ifs.sv @@
`default_nettype none

// incoming peak channel
interface tpt_peak_if;
  logic                        valid;
  logic                        ready;
  logic [tpt_pkg::VALUE_W-1:0] peak_value;
  logic [tpt_pkg::BIN_W-1:0]   peak_bin;

  modport source (output valid, output peak_value, output peak_bin, input ready);
  modport sink (input valid, input peak_value, input peak_bin, output ready);
endinterface

// report channel, one transaction per reporting period
interface tpt_report_if;
  logic                        valid;
  logic                        ready;
  logic [tpt_pkg::VALUE_W-1:0] first_value;
  logic [tpt_pkg::BIN_W-1:0]   first_bin;
  logic [tpt_pkg::COUNT_W-1:0] first_count;
  logic [tpt_pkg::VALUE_W-1:0] second_value;
  logic [tpt_pkg::BIN_W-1:0]   second_bin;
  logic [tpt_pkg::COUNT_W-1:0] second_count;
  logic [tpt_pkg::VALUE_W-1:0] third_value;
  logic [tpt_pkg::BIN_W-1:0]   third_bin;
  logic [tpt_pkg::COUNT_W-1:0] third_count;
  logic [tpt_pkg::VALUE_W-1:0] fourth_value;
  logic [tpt_pkg::BIN_W-1:0]   fourth_bin;
  logic [tpt_pkg::COUNT_W-1:0] fourth_count;

  modport source (
    output valid,
    output first_value, output first_bin, output first_count,
    output second_value, output second_bin, output second_count,
    output third_value, output third_bin, output third_count,
    output fourth_value, output fourth_bin, output fourth_count,
    input ready
  );
  modport sink (
    input valid,
    input first_value, input first_bin, input first_count,
    input second_value, input second_bin, input second_count,
    input third_value, input third_bin, input third_count,
    input fourth_value, input fourth_bin, input fourth_count,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/tpt_cell.sv @@
`default_nettype none

// one slot of the sorted chain
module tpt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tpt_pkg::cell_ctl_t ctl_i,
  input  wire logic              head_i,
  input  wire logic              prev_gt_i,
  input  wire tpt_pkg::slot_t    nbr_i,
  output      logic              gt_o,
  output      tpt_pkg::slot_t    slot_o
);

  tpt_pkg::slot_t slot_q, slot_d;
  logic           gt;

  // strict compare against the incoming peak
  assign gt = ctl_i.entry.value > slot_q.value;

  // next slot: seed or clear on flush, else shift from above or insert
  always_comb begin
    slot_d = slot_q;
    if (ctl_i.accept) begin
      if (ctl_i.flush) begin
        slot_d = head_i ? ctl_i.entry : '0;
      end else if (prev_gt_i) begin
        slot_d = nbr_i;
      end else if (gt) begin
        slot_d = ctl_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign gt_o   = gt;
  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ hdl/top4_peak_tracker_unit.sv @@
// Top-four peak tracker.
// peak_i is a valid/ready channel of peaks (value, bin); one transaction is
// taken per clock when the report register is empty or being drained.
// report_o carries the four largest values of the period, descending, each
// with its bin and the halved period timer at insertion; empty slots read 0.
// cfg_we_i/cfg_wdata_i write flush_period (reset 1024); the user must write
// it only while the block idles, the block does not enforce this. Every
// peak updates the chain of four slot cells in the cycle it is accepted;
// the peak finding the timer at or above flush_period-1 pushes the four slots
// into the report register, valid in the next cycle, and seeds slot 0 itself.
// If the receiver stalls, the report is held and peak_i.ready stays low
// while the report register is occupied, so no peak is taken until
// report_o is taken; in the cycle it is taken a new peak may enter.
// Reset clears all slots, the timer and the report valid flag; the threshold
// returns to 1023. No clearing pass is needed.
`default_nettype none
`include "top4_peak_tracker_unit_macros.svh"

module top4_peak_tracker_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tpt_peak_if.sink                         peak_i,
  tpt_report_if.source                     report_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tpt_pkg::TIMER_W-1:0] cfg_wdata_i
);

  logic [tpt_pkg::TIMER_W-1:0] thr_q, timer_q, timer_d;
  logic                        flush, accept, out_valid_q;
  tpt_pkg::cell_ctl_t          ctl;
  tpt_pkg::slot_t              slot_w [tpt_pkg::SLOTS];
  tpt_pkg::slot_t              rpt_q  [tpt_pkg::SLOTS];
  logic [tpt_pkg::SLOTS-1:0]   gt_w;

  // handshake: the report register parts the two sides
  assign peak_i.ready = !out_valid_q || report_o.ready;
  assign accept       = peak_i.valid && peak_i.ready;
  assign flush        = timer_q >= thr_q;

  // broadcast to the cells
  always_comb begin
    ctl.accept      = accept;
    ctl.flush       = flush;
    ctl.entry.value = peak_i.peak_value;
    ctl.entry.bin   = peak_i.peak_bin;
    ctl.entry.count = flush ? '0 : timer_q[tpt_pkg::TIMER_W-1:1];
  end

  // chain of slot cells
  for (genvar i = 0; i < tpt_pkg::SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tpt_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (ctl),
        .head_i    (1'b1),
        .prev_gt_i (1'b0),
        .nbr_i     ('0),
        .gt_o      (gt_w[i]),
        .slot_o    (slot_w[i])
      );
    end else begin : g_body
      tpt_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (ctl),
        .head_i    (1'b0),
        .prev_gt_i (gt_w[i-1]),
        .nbr_i     (slot_w[i-1]),
        .gt_o      (gt_w[i]),
        .slot_o    (slot_w[i])
      );
    end
  end

  // period timer
  always_comb begin
    timer_d = timer_q;
    if (accept) begin
      timer_d = flush ? tpt_pkg::TIMER_W'(1) : timer_q + tpt_pkg::TIMER_W'(1);
    end
  end

  // threshold, timer and report valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= tpt_pkg::FLUSH_RESET - tpt_pkg::TIMER_W'(1);
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i - tpt_pkg::TIMER_W'(1);
      end
      timer_q <= timer_d;
      if (accept && flush) begin
        out_valid_q <= 1'b1;
      end else if (report_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // report payload
  always_ff @(posedge clk_i) begin
    if (accept && flush) begin
      for (int i = 0; i < tpt_pkg::SLOTS; i++) begin
        rpt_q[i] <= slot_w[i];
      end
    end
  end

  assign report_o.valid        = out_valid_q;
  assign report_o.first_value  = rpt_q[0].value;
  assign report_o.first_bin    = rpt_q[0].bin;
  assign report_o.first_count  = rpt_q[0].count;
  assign report_o.second_value = rpt_q[1].value;
  assign report_o.second_bin   = rpt_q[1].bin;
  assign report_o.second_count = rpt_q[1].count;
  assign report_o.third_value  = rpt_q[2].value;
  assign report_o.third_bin    = rpt_q[2].bin;
  assign report_o.third_count  = rpt_q[2].count;
  assign report_o.fourth_value = rpt_q[3].value;
  assign report_o.fourth_bin   = rpt_q[3].bin;
  assign report_o.fourth_count = rpt_q[3].count;

  // slots stay in descending order
  `TPT_ASSERT_ALWAYS(a_sorted, (slot_w[0].value >= slot_w[1].value) && (slot_w[1].value >= slot_w[2].value) && (slot_w[2].value >= slot_w[3].value))
  // a peak beating one slot beats every slot below it
  `TPT_ASSERT_ALWAYS(a_gt_monotone, (!gt_w[0] || gt_w[1]) && (!gt_w[1] || gt_w[2]) && (!gt_w[2] || gt_w[3]))
  // a flush fills the report register
  `TPT_ASSERT_NEXT(a_flush_report, accept && flush, out_valid_q)
  // a flush restarts the timer at one
  `TPT_ASSERT_NEXT(a_flush_timer, accept && flush, timer_q == tpt_pkg::TIMER_W'(1))

endmodule

`default_nettype wire

@@ test/top4_peak_report_checker.sv @@
`timescale 1ns / 100ps

module top4_peak_report_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tpt_peak_if                              peak_i,
  tpt_report_if                            report_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [tpt_pkg::TIMER_W-1:0] cfg_wdata_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      reports_due_o
);
  import tpt_pkg::*;

  // index 0 holds the largest value
  typedef slot_t [SLOTS-1:0] ranking_t;

  ranking_t           expected_reports [$];
  slot_t              kept [SLOTS];
  logic [TIMER_W-1:0] period_timer;
  logic [TIMER_W-1:0] flush_period;

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  // one peak transaction: closes the period and seeds slot 0, or is ranked
  task automatic rank_peak(input logic [VALUE_W-1:0] value, input logic [BIN_W-1:0] bin);
    ranking_t snap;
    int       pos;
    pos = SLOTS;
    if (period_timer >= flush_period - 32'd1) begin
      for (int i = 0; i < SLOTS; i++) begin
        snap[i] = kept[i];
        kept[i] = '0;
      end
      expected_reports.push_back(snap);
      kept[0] = {value, bin, {COUNT_W{1'b0}}};
      period_timer = 32'd1;
    end else begin
      // slots stay sorted, so the lowest index holding a smaller value wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (value > kept[i].value) pos = i;
      end
      if (pos < SLOTS) begin
        for (int i = SLOTS - 1; i > pos; i--) kept[i] = kept[i-1];
        kept[pos] = {value, bin, period_timer[TIMER_W-1:1]};
      end
      period_timer = period_timer + 32'd1;
    end
  endtask

  // compare one report transaction with the oldest closed period
  task automatic check_report();
    ranking_t got;
    ranking_t want;
    got[0] = {report_i.first_value, report_i.first_bin, report_i.first_count};
    got[1] = {report_i.second_value, report_i.second_bin, report_i.second_count};
    got[2] = {report_i.third_value, report_i.third_bin, report_i.third_count};
    got[3] = {report_i.fourth_value, report_i.fourth_bin, report_i.fourth_count};
    if (expected_reports.size() == 0) begin
      note_mismatch("report with no closed period waiting");
      return;
    end
    want = expected_reports.pop_front();
    for (int r = 0; r < SLOTS; r++) begin
      if (got[r].value !== want[r].value)
        note_mismatch($sformatf("rank %0d value: got %0h, expected %0h",
                                r, got[r].value, want[r].value));
      if (got[r].bin !== want[r].bin)
        note_mismatch($sformatf("rank %0d bin: got %0h, expected %0h",
                                r, got[r].bin, want[r].bin));
      if (got[r].count !== want[r].count)
        note_mismatch($sformatf("rank %0d count: got %0h, expected %0h",
                                r, got[r].count, want[r].count));
    end
  endtask

  // watch register writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (kept[i]) kept[i] = '0;
      period_timer = '0;
      flush_period = FLUSH_RESET;
      expected_reports.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) flush_period = cfg_wdata_i;
      if (report_i.valid && report_i.ready) check_report();
      if (peak_i.valid && peak_i.ready) rank_peak(peak_i.peak_value, peak_i.peak_bin);
    end
    reports_due_o = expected_reports.size();
  end

endmodule

@@ test/top4_peak_tracker_unit_test.sv @@
`timescale 1ns / 100ps

module top4_peak_tracker_unit_test;
  import tpt_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [TIMER_W-1:0] cfg_wdata = '0;
  bit                 idle_on = 1'b1;
  int unsigned        mismatch_count;
  int unsigned        reports_due;

  tpt_peak_if   peak_ch ();
  tpt_report_if report_ch ();

  top4_peak_tracker_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .peak_i      (peak_ch),
    .report_o    (report_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  top4_peak_report_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .peak_i           (peak_ch),
    .report_i         (report_ch),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due)
  );

  always #1 clk_i = ~clk_i;

  // one peak transaction, with an occasional gap in front of it
  task automatic send_peak(input logic [VALUE_W-1:0] value, input logic [BIN_W-1:0] bin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      peak_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    peak_ch.valid      <= 1'b1;
    peak_ch.peak_value <= value;
    peak_ch.peak_bin   <= bin;
    do @(posedge clk_i); while (!peak_ch.ready);
    @(negedge clk_i);
  endtask

  // write the period once the block has drained
  task automatic set_flush_period(input logic [TIMER_W-1:0] period);
    peak_ch.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata <= period;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mix of zeros, full scale, repeats for ties, small and random values
  function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return prev;
      3:       return VALUE_W'($urandom_range(0, 15));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // report side stalls in short bursts, with ready raised again between them
  initial begin
    int stall_left;
    stall_left = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        report_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && report_ch.ready && $urandom_range(0, 4) == 0) begin
        report_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [VALUE_W-1:0] value;
    int unsigned        phase_period [10];
    value              = '0;
    phase_period       = '{1, 2, 3, 4, 5, 7, 13, 16, 0, 6};
    phase_period[8]    = $urandom_range(1, 40);
    peak_ch.valid      = 1'b0;
    peak_ch.peak_value = '0;
    peak_ch.peak_bin   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default period: zero never enters an empty slot, ties keep the older entry
    send_peak(16'h0000, 10'h3FF);
    send_peak(16'hFFFF, 10'h3FF);
    send_peak(16'h1234, 10'h001);
    send_peak(16'h1234, 10'h002);
    send_peak(16'h8000, 10'h200);
    send_peak(16'h0001, 10'h155);
    send_peak(16'h7FFF, 10'h0AA);
    send_peak(16'hFFFF, 10'h000);
    send_peak(16'h0000, 10'h000);
    // period below the running timer flushes at once, then every peak flushes
    set_flush_period(32'd1);
    send_peak(16'hABCD, 10'h3FF);
    send_peak(16'h5555, 10'h2AA);
    // zero period wraps to the largest threshold
    set_flush_period(32'd0);
    send_peak(16'h00FF, 10'h0F0);
    send_peak(16'hFF00, 10'h30F);
    send_peak(16'h00FF, 10'h0F1);
    set_flush_period(32'hFFFF_FFFF);
    send_peak(16'h0002, 10'h001);
    send_peak(16'hFFFE, 10'h3FE);
    set_flush_period(32'd2);
    send_peak(16'h4000, 10'h100);
    send_peak(16'h0000, 10'h3FF);
    send_peak(16'hC000, 10'h200);
    send_peak(16'hC000, 10'h201);

    // random phases over several periods, last one without idling
    for (int p = 0; p < 10; p++) begin
      idle_on = (p % 3 != 2) && (p != 9);
      set_flush_period(phase_period[p]);
      repeat (165) begin
        value = pick_value(value);
        send_peak(value, BIN_W'($urandom_range(0, 1023)));
      end
    end

    peak_ch.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS top4_peak_tracker_unit");
    end else begin
      $display("FAIL top4_peak_tracker_unit");
    end
    $finish;
  end

  // hang guard
  initial begin
    #400000;
    $display("FAIL top4_peak_tracker_unit");
    $finish;
  end

endmodule
